/* rtl/core/tls_pkg.sv */
// Package with the types and constants of the traffic light sequencer.
package tls_pkg;

  localparam int unsigned CfgDataWidth = 7;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_GREEN_ROAD1   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_GREEN_ROAD2   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_YELLOW        = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_MANUAL_YELLOW = 2'd3;

  localparam logic [6:0] GREEN_ROAD1_RESET   = 7'd19;
  localparam logic [6:0] GREEN_ROAD2_RESET   = 7'd11;
  localparam logic [3:0] YELLOW_RESET        = 4'd3;
  localparam logic [3:0] MANUAL_YELLOW_RESET = 4'd3;

  localparam logic [6:0] GREEN_MAX         = 7'd90;
  localparam logic [3:0] YELLOW_MAX        = 4'd8;
  localparam logic [3:0] MANUAL_YELLOW_MAX = 4'd9;
  localparam logic [3:0] MANUAL_YELLOW_MIN = 4'd1;
  localparam logic [6:0] COUNT_MAX         = 7'd99;

  localparam logic [1:0] DISP_BLANK  = 2'd0;
  localparam logic [1:0] DISP_COUNT  = 2'd1;
  localparam logic [1:0] DISP_UNITS  = 2'd2;

  typedef enum logic [2:0] {
    PH_GREEN1   = 3'd0,
    PH_YELLOW1  = 3'd1,
    PH_GREEN2   = 3'd2,
    PH_YELLOW2  = 3'd3,
    PH_MYELLOW1 = 3'd4,
    PH_MGREEN1  = 3'd5,
    PH_MYELLOW2 = 3'd6,
    PH_MGREEN2  = 3'd7
  } phase_e;

  typedef struct packed {
    logic mode_press;
    logic manual_switch;
  } tls_in_t;

  typedef struct packed {
    logic       road1_red;
    logic       road1_yellow;
    logic       road1_green;
    logic       road2_red;
    logic       road2_yellow;
    logic       road2_green;
    logic [6:0] road1_count;
    logic [6:0] road2_count;
    logic [1:0] display_kind;
    logic       in_manual;
  } tls_out_t;

endpackage

/* rtl/core/traffic_light_sequencer_core.sv */
// Top level of the traffic light sequencer: mode, phase and countdown logic.
//
// The block takes one transaction on the input channel per one-second tick.
// Each carries a mode-button press and the manual switch level. For every
// input transaction it returns exactly one output transaction holding the
// six lamps, the two displayed counts, the display kind and the mode bit.
// Both channels use valid and stall; a transaction moves at a clock edge
// with valid high and stall low.
// The result of a tick appears in the output register in the cycle after the
// input is accepted, and one tick can be accepted in every cycle unless that
// register is full and stalled. The state update is combinational compare
// and add logic feeding the output register, the only register on the path.
// When the receiver stalls, the result holds in the output register and the
// input channel is stalled only while that register is full and stalled.
// Reset starts the block in manual mode with the road one yellow count-up,
// both counts at zero and the configuration registers at their defaults.
// Configuration writes take effect at the next phase load or, for the manual
// yellow length, at its next end test.
module traffic_light_sequencer_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  tls_pkg::tls_in_t                       in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output tls_pkg::tls_out_t                      out_data_o,
  input  logic                                   cfg_we_i,
  input  logic [tls_pkg::CfgIdxWidth-1:0]        cfg_idx_i,
  input  logic [tls_pkg::CfgDataWidth-1:0]       cfg_data_i
);
  import tls_pkg::*;

  logic [6:0] cfg_green1_q, cfg_green2_q;
  logic [3:0] cfg_yellow_q, cfg_myellow_q;
  logic [6:0] green1_c, green2_c;
  logic [3:0] yellow_c, myellow_c;
  logic [6:0] red_after1, red_after2;

  logic       mode_q, mode_d, mode_a;
  phase_e     phase_q, phase_d, phase_a;
  logic [6:0] road1_left_q, road1_left_d, road1_left_a;
  logic [6:0] road2_left_q, road2_left_d, road2_left_a;
  logic [6:0] road1_up;
  logic [6:0] gov_left;

  logic       in_acc;
  logic       out_valid_q;
  tls_out_t   out_q, out_d;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_green1_q  <= GREEN_ROAD1_RESET;
      cfg_green2_q  <= GREEN_ROAD2_RESET;
      cfg_yellow_q  <= YELLOW_RESET;
      cfg_myellow_q <= MANUAL_YELLOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GREEN_ROAD1:   cfg_green1_q  <= cfg_data_i;
        CFG_GREEN_ROAD2:   cfg_green2_q  <= cfg_data_i;
        CFG_YELLOW:        cfg_yellow_q  <= cfg_data_i[3:0];
        CFG_MANUAL_YELLOW: cfg_myellow_q <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    green1_c   = (cfg_green1_q > GREEN_MAX) ? GREEN_MAX : cfg_green1_q;
    green2_c   = (cfg_green2_q > GREEN_MAX) ? GREEN_MAX : cfg_green2_q;
    yellow_c   = (cfg_yellow_q > YELLOW_MAX) ? YELLOW_MAX : cfg_yellow_q;
    myellow_c  = (cfg_myellow_q > MANUAL_YELLOW_MAX) ? MANUAL_YELLOW_MAX : cfg_myellow_q;
    if (myellow_c == 4'd0) begin
      myellow_c = MANUAL_YELLOW_MIN;
    end
    red_after1 = 7'(green1_c + {3'd0, yellow_c} + 7'd1);
    red_after2 = 7'(green2_c + {3'd0, yellow_c} + 7'd1);
  end

  // The press is applied first, then the manual switch level.
  always_comb begin
    mode_a       = mode_q;
    phase_a      = phase_q;
    road1_left_a = road1_left_q;
    road2_left_a = road2_left_q;
    if (in_data_i.mode_press) begin
      mode_a       = ~mode_q;
      road1_left_a = 7'd0;
      road2_left_a = 7'd0;
      if (mode_q) begin
        phase_a      = PH_GREEN1;
        road1_left_a = green1_c;
        road2_left_a = red_after1;
      end else begin
        phase_a = PH_MYELLOW1;
      end
    end
    if (mode_a) begin
      if (phase_a == PH_MGREEN1 && in_data_i.manual_switch) begin
        phase_a      = PH_MYELLOW2;
        road1_left_a = 7'd0;
      end else if (phase_a == PH_MGREEN2 && !in_data_i.manual_switch) begin
        phase_a      = PH_MYELLOW1;
        road1_left_a = 7'd0;
      end
    end
  end

  assign road1_up = 7'(road1_left_a + 7'd1);
  assign gov_left = phase_a[1] ? road2_left_a : road1_left_a;

  always_comb begin
    out_d              = '0;
    out_d.in_manual    = mode_a;
    case (phase_a)
      PH_GREEN1: begin
        out_d.road1_green = 1'b1;
        out_d.road2_red   = 1'b1;
      end
      PH_YELLOW1: begin
        out_d.road1_yellow = 1'b1;
        out_d.road2_red    = 1'b1;
      end
      PH_GREEN2: begin
        out_d.road1_red   = 1'b1;
        out_d.road2_green = 1'b1;
      end
      PH_YELLOW2: begin
        out_d.road1_red    = 1'b1;
        out_d.road2_yellow = 1'b1;
      end
      PH_MYELLOW1: begin
        out_d.road1_yellow = 1'b1;
        out_d.road1_count  = road1_up;
        out_d.display_kind = DISP_UNITS;
      end
      PH_MGREEN1: begin
        out_d.road1_green = 1'b1;
        out_d.road2_red   = 1'b1;
      end
      PH_MYELLOW2: begin
        out_d.road2_yellow = 1'b1;
        out_d.road1_count  = road1_up;
        out_d.display_kind = DISP_UNITS;
      end
      PH_MGREEN2: begin
        out_d.road1_red   = 1'b1;
        out_d.road2_green = 1'b1;
      end
      default: begin
      end
    endcase
    if (!mode_a) begin
      out_d.road1_count  = road1_left_a;
      out_d.road2_count  = road2_left_a;
      out_d.display_kind = DISP_COUNT;
    end
  end

  always_comb begin
    mode_d       = mode_a;
    phase_d      = phase_a;
    road1_left_d = road1_left_a;
    road2_left_d = road2_left_a;
    case (phase_a)
      PH_MYELLOW1, PH_MYELLOW2: begin
        if (road1_up < {3'd0, myellow_c}) begin
          road1_left_d = road1_up;
        end else begin
          phase_d      = (phase_a == PH_MYELLOW1) ? PH_MGREEN1 : PH_MGREEN2;
          road1_left_d = 7'd0;
        end
      end
      PH_MGREEN1, PH_MGREEN2: begin
      end
      default: begin
        if (gov_left == 7'd0) begin
          case (phase_a)
            PH_GREEN1: begin
              phase_d      = PH_YELLOW1;
              road1_left_d = {3'd0, yellow_c};
              road2_left_d = {3'd0, yellow_c};
            end
            PH_YELLOW1: begin
              phase_d      = PH_GREEN2;
              road1_left_d = red_after2;
              road2_left_d = green2_c;
            end
            PH_GREEN2: begin
              phase_d      = PH_YELLOW2;
              road1_left_d = {3'd0, yellow_c};
              road2_left_d = {3'd0, yellow_c};
            end
            default: begin
              phase_d      = PH_GREEN1;
              road1_left_d = green1_c;
              road2_left_d = red_after1;
            end
          endcase
        end else begin
          if (road1_left_a != 7'd0) begin
            road1_left_d = 7'(road1_left_a - 7'd1);
          end
          if (road2_left_a != 7'd0) begin
            road2_left_d = 7'(road2_left_a - 7'd1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b1;
      phase_q      <= PH_MYELLOW1;
      road1_left_q <= 7'd0;
      road2_left_q <= 7'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_q       <= mode_d;
        phase_q      <= phase_d;
        road1_left_q <= road1_left_d;
        road2_left_q <= road2_left_d;
      end
      out_valid_q <= in_acc | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == phase_q[2])
    else $error("Mode bit and phase group disagree.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_manual |->
      $onehot({out_data_o.road1_red, out_data_o.road1_yellow, out_data_o.road1_green}) &&
      $onehot({out_data_o.road2_red, out_data_o.road2_yellow, out_data_o.road2_green}) &&
      out_data_o.display_kind == DISP_COUNT)
    else $error("Auto mode result has a bad lamp set or display kind.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.road1_count <= COUNT_MAX &&
                    out_data_o.road2_count <= COUNT_MAX)
    else $error("Displayed count out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("Accepted transaction produced no result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result was lost or changed.");

endmodule

/* test/testbench.sv */
// Testbench for the traffic light sequencer core: directed and random ticks checked per field.
module testbench;
  import tls_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 64;
  localparam int unsigned MaxPrinted    = 30;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  tls_in_t                 in_data_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  tls_out_t                out_data_o;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_data_i;

  logic [6:0] green1_setting;
  logic [6:0] green2_setting;
  logic [3:0] yellow_setting;
  logic [3:0] manual_yellow_setting;
  logic       manual_on;
  phase_e     light_phase;
  logic [6:0] road1_remaining;
  logic [6:0] road2_remaining;

  tls_out_t    lamp_results_q[$];
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned manual_ticks = 0;
  int unsigned results_checked = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned register_writes = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sender_quiet = 0;
  bit          idling_on;
  bit          hold_req;
  logic        switch_level;

  traffic_light_sequencer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [6:0] clamp7(logic [6:0] value, logic [6:0] limit);
    return (value > limit) ? limit : value;
  endfunction

  function automatic void reset_light_model();
    green1_setting        = GREEN_ROAD1_RESET;
    green2_setting        = GREEN_ROAD2_RESET;
    yellow_setting        = YELLOW_RESET;
    manual_yellow_setting = MANUAL_YELLOW_RESET;
    manual_on             = 1'b1;
    light_phase           = PH_MYELLOW1;
    road1_remaining       = '0;
    road2_remaining       = '0;
  endfunction

  function automatic void load_phase_counts();
    logic [6:0] g1;
    logic [6:0] g2;
    logic [6:0] y;
    g1 = clamp7(green1_setting, GREEN_MAX);
    g2 = clamp7(green2_setting, GREEN_MAX);
    y  = clamp7({3'b000, yellow_setting}, {3'b000, YELLOW_MAX});
    case (light_phase)
      PH_GREEN1: begin
        road1_remaining = g1;
        road2_remaining = g1 + y + 7'd1;
      end
      PH_GREEN2: begin
        road1_remaining = g2 + y + 7'd1;
        road2_remaining = g2;
      end
      default: begin
        road1_remaining = y;
        road2_remaining = y;
      end
    endcase
  endfunction

  // Applies one tick to the light model and returns the lamps shown for it.
  function automatic tls_out_t predict_lamps(tls_in_t tick);
    tls_out_t   lamps;
    logic [3:0] up_len;
    logic [6:0] governing;
    lamps = '0;
    if (tick.mode_press) begin
      manual_on       = !manual_on;
      road1_remaining = '0;
      road2_remaining = '0;
      if (manual_on) begin
        light_phase = PH_MYELLOW1;
      end else begin
        light_phase = PH_GREEN1;
        load_phase_counts();
      end
    end
    if (manual_on) begin
      if (light_phase == PH_MGREEN1 && tick.manual_switch) begin
        light_phase     = PH_MYELLOW2;
        road1_remaining = '0;
      end else if (light_phase == PH_MGREEN2 && !tick.manual_switch) begin
        light_phase     = PH_MYELLOW1;
        road1_remaining = '0;
      end
      case (light_phase)
        PH_MYELLOW1: begin
          lamps.road1_yellow = 1'b1;
          lamps.road1_count  = road1_remaining + 7'd1;
          lamps.display_kind = DISP_UNITS;
        end
        PH_MGREEN1: begin
          lamps.road1_green = 1'b1;
          lamps.road2_red   = 1'b1;
        end
        PH_MYELLOW2: begin
          lamps.road2_yellow = 1'b1;
          lamps.road1_count  = road1_remaining + 7'd1;
          lamps.display_kind = DISP_UNITS;
        end
        default: begin
          lamps.road2_green = 1'b1;
          lamps.road1_red   = 1'b1;
        end
      endcase
      lamps.in_manual = 1'b1;
    end else begin
      case (light_phase)
        PH_GREEN1: begin
          lamps.road1_green = 1'b1;
          lamps.road2_red   = 1'b1;
        end
        PH_YELLOW1: begin
          lamps.road1_yellow = 1'b1;
          lamps.road2_red    = 1'b1;
        end
        PH_GREEN2: begin
          lamps.road1_red   = 1'b1;
          lamps.road2_green = 1'b1;
        end
        default: begin
          lamps.road1_red    = 1'b1;
          lamps.road2_yellow = 1'b1;
        end
      endcase
      lamps.road1_count  = road1_remaining;
      lamps.road2_count  = road2_remaining;
      lamps.display_kind = DISP_COUNT;
    end

    if (manual_on) begin
      if (light_phase == PH_MYELLOW1 || light_phase == PH_MYELLOW2) begin
        up_len = (manual_yellow_setting > MANUAL_YELLOW_MAX) ? MANUAL_YELLOW_MAX
                                                             : manual_yellow_setting;
        if (up_len < MANUAL_YELLOW_MIN) up_len = MANUAL_YELLOW_MIN;
        if (road1_remaining + 7'd1 < {3'b000, up_len}) begin
          road1_remaining = road1_remaining + 7'd1;
        end else begin
          light_phase     = (light_phase == PH_MYELLOW1) ? PH_MGREEN1 : PH_MGREEN2;
          road1_remaining = '0;
        end
      end
    end else begin
      governing = (light_phase == PH_GREEN1 || light_phase == PH_YELLOW1) ? road1_remaining
                                                                           : road2_remaining;
      if (governing == 7'd0) begin
        case (light_phase)
          PH_GREEN1:  light_phase = PH_YELLOW1;
          PH_YELLOW1: light_phase = PH_GREEN2;
          PH_GREEN2:  light_phase = PH_YELLOW2;
          default:    light_phase = PH_GREEN1;
        endcase
        load_phase_counts();
      end else begin
        if (road1_remaining != 7'd0) road1_remaining = road1_remaining - 7'd1;
        if (road2_remaining != 7'd0) road2_remaining = road2_remaining - 7'd1;
      end
    end
    return lamps;
  endfunction

  function automatic tls_in_t tick_of(logic press, logic sw);
    tls_in_t tick;
    tick.mode_press    = press;
    tick.manual_switch = sw;
    return tick;
  endfunction

  // Mostly steady switch levels and rare presses, with some fully random noise.
  function automatic tls_in_t random_tick(int unsigned press_odds);
    if ($urandom_range(0, 9) == 0) return tls_in_t'(2'($urandom_range(0, 3)));
    if ($urandom_range(0, 5) == 0) switch_level = !switch_level;
    return tick_of($urandom_range(1, press_odds) == 1, switch_level);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("MISMATCH result %0d %s: got %0d, expected %0d",
               results_checked, what, got, want);
    end
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic send_tick(tls_in_t tick);
    int unsigned gap;
    tls_out_t    lamps;
    if (idling_on && sender_quiet == 0 && $urandom_range(0, 19) == 0) begin
      sender_quiet = $urandom_range(10, 40);
    end
    if (sender_quiet != 0) begin
      sender_quiet--;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= tick;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    lamps = predict_lamps(tick);
    lamp_results_q.push_back(lamps);
    ticks_sent++;
    if (lamps.in_manual) manual_ticks++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lamp_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_GREEN_ROAD1: green1_setting = value;
      CFG_GREEN_ROAD2: green2_setting = value;
      CFG_YELLOW:      yellow_setting = value[3:0];
      default:         manual_yellow_setting = value[3:0];
    endcase
    register_writes++;
  endtask

  task automatic set_timing(logic [6:0] g1, logic [6:0] g2, logic [6:0] y, logic [6:0] my);
    wait_for_drain();
    write_register(CFG_GREEN_ROAD1, g1);
    write_register(CFG_GREEN_ROAD2, g2);
    write_register(CFG_YELLOW, y);
    write_register(CFG_MANUAL_YELLOW, my);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Manual mode from reset: count-ups, green holds, and a hold that is released at once.
  task automatic test_manual_walk();
    repeat (5) send_tick(tick_of(1'b0, 1'b0));
    send_tick(tick_of(1'b0, 1'b1));
    repeat (2) send_tick(tick_of(1'b0, 1'b0));
    send_tick(tick_of(1'b0, 1'b0));
    repeat (2) send_tick(tick_of(1'b0, 1'b1));
    send_tick(tick_of(1'b0, 1'b1));
  endtask

  task automatic test_mode_toggle();
    send_tick(tick_of(1'b1, 1'b1));
    repeat (3) send_tick(tick_of(1'b0, 1'b1));
    send_tick(tick_of(1'b1, 1'b0));
    send_tick(tick_of(1'b1, 1'b0));
    repeat (2) send_tick(tick_of(1'b0, 1'b0));
    send_tick(tick_of(1'b1, 1'b1));
  endtask

  // All counts at zero, so every auto phase lasts one tick and a zero count-up acts as one.
  task automatic test_short_phases();
    set_timing(7'd0, 7'd0, 7'd0, 7'd0);
    send_tick(tick_of(1'b1, 1'b0));
    repeat (8) send_tick(tick_of(1'b0, 1'b0));
    send_tick(tick_of(1'b1, 1'b0));
    send_tick(tick_of(1'b0, 1'b1));
    send_tick(tick_of(1'b0, 1'b1));
    send_tick(tick_of(1'b0, 1'b0));
    send_tick(tick_of(1'b0, 1'b0));
    send_tick(tick_of(1'b0, 1'b1));
  endtask

  // Register values above their limits, including set upper bits on the short registers.
  task automatic test_register_limits();
    set_timing(7'd127, 7'd91, 7'h7F, 7'd15);
    send_tick(tick_of(1'b1, 1'b0));
    repeat (205) send_tick(tick_of(1'b0, 1'($urandom_range(0, 1))));
    send_tick(tick_of(1'b1, 1'b0));
    repeat (12) send_tick(tick_of(1'b0, 1'b0));
  endtask

  task automatic test_random_settings();
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: set_timing(7'd90, 7'd90, 7'd8, 7'd9);
        1: set_timing(7'd1, 7'd0, 7'd8, 7'd1);
        default: set_timing(7'($urandom_range(0, 127)), 7'($urandom_range(0, 20)),
                             7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      endcase
      repeat (70) send_tick(random_tick(25));
    end
  endtask

  task automatic test_backpressure();
    bit saved_idling;
    saved_idling = idling_on;
    set_timing(7'd4, 7'd6, 7'd2, 7'd4);
    idling_on = 1'b0;
    hold_req  = 1'b1;
    repeat (40) send_tick(random_tick(10));
    idling_on = saved_idling;
  endtask

  task automatic test_steady_tail();
    set_timing(GREEN_ROAD1_RESET, GREEN_ROAD2_RESET, YELLOW_RESET, MANUAL_YELLOW_RESET);
    idling_on = 1'b0;
    repeat (80) send_tick(random_tick(20));
  endtask

  always @(posedge clk_i) begin : result_check
    tls_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lamp_results_q.size() == 0) begin
        report_mismatch("result with nothing expected", 1, 0);
      end else begin
        want = lamp_results_q.pop_front();
        check_field("road1_red", out_data_o.road1_red, want.road1_red);
        check_field("road1_yellow", out_data_o.road1_yellow, want.road1_yellow);
        check_field("road1_green", out_data_o.road1_green, want.road1_green);
        check_field("road2_red", out_data_o.road2_red, want.road2_red);
        check_field("road2_yellow", out_data_o.road2_yellow, want.road2_yellow);
        check_field("road2_green", out_data_o.road2_green, want.road2_green);
        check_field("road1_count", out_data_o.road1_count, want.road1_count);
        check_field("road2_count", out_data_o.road2_count, want.road2_count);
        check_field("display_kind", out_data_o.display_kind, want.display_kind);
        check_field("in_manual", out_data_o.in_manual, want.in_manual);
      end
      results_checked++;
    end
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no transaction for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned busy_left;
    int unsigned steady_left;
    busy_left   = 0;
    steady_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        busy_left   = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else if (busy_left != 0) begin
        busy_left--;
        out_stall_i <= 1'b1;
      end else if (steady_left != 0 || !idling_on) begin
        if (steady_left != 0) steady_left--;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        steady_left = $urandom_range(20, 60);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        busy_left   = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    idling_on    = 1'b1;
    hold_req     = 1'b0;
    switch_level = 1'b0;
    reset_light_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_manual_walk();
    test_mode_toggle();
    test_short_phases();
    test_register_limits();
    test_random_settings();
    test_backpressure();
    test_steady_tail();

    wait_for_drain();
    repeat (4) @(posedge clk_i);
    $display("Ran %0d ticks (%0d in manual mode) across %0d register writes, %0d results checked.",
             ticks_sent, manual_ticks, register_writes, results_checked);
    $display("Input was held off for %0d cycles; %0d field mismatches found.",
             input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/tls_pkg.sv
rtl/core/traffic_light_sequencer_core.sv
test/testbench.sv
